@@ rtl/core/json_string_skip_scanner_unit_defines.svh @@
// Assertion macros for the JSON string scanner.
// Depends on nothing; the including module supplies clk and rst.
`ifndef JSON_STRING_SKIP_SCANNER_UNIT_DEFINES_SVH
`define JSON_STRING_SKIP_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JSSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/jsss_pkg.sv @@
// Shared constants and helpers for the JSON string scanner.
// Depends on nothing.
package jsss_pkg;

  localparam int FIELD_W         = 32;
  localparam int BYTE_W          = 8;
  localparam int INDEX_BITS_DEF  = 32;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BODY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ESC  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd3;

  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT   = 8'h20;

  localparam int HEX_W = 3;
  localparam logic [HEX_W-1:0] HEX_COUNT = 3'd4;

  function automatic logic is_hex_digit(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage

@@ rtl/core/json_string_skip_scanner_unit.sv @@
// JSON string scanner: takes one buffer byte per request, starting at a byte
// marked first that carries the start index and buffer length, and returns one
// result per scan: the index after the closing quote, or failed with the length.
// It takes one byte every cycle unless stalled; a byte goes from the input register
// to the result register, which loads together with the mode and index registers.
// Input stalls only while a result waits in an output register that is not drained.
// Bytes after a result are dropped until the next first byte. No clearing pass.
// Depends on jsss_pkg and json_string_skip_scanner_unit_defines.svh.
`include "json_string_skip_scanner_unit_defines.svh"

module json_string_skip_scanner_unit #(
  parameter int INDEX_BITS = jsss_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jsss_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                first,
  input  logic [jsss_pkg::FIELD_W-1:0]        start_index,
  input  logic [jsss_pkg::FIELD_W-1:0]        buffer_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jsss_pkg::FIELD_W-1:0]        end_index,
  output logic                                failed
);
  import jsss_pkg::*;

  // input register
  logic                   s1_valid;
  logic [BYTE_W-1:0]      s1_byte;
  logic                   s1_first;
  logic [INDEX_BITS-1:0]  s1_start;
  logic [INDEX_BITS-1:0]  s1_len;

  // scan state
  logic [MODE_W-1:0]      mode, mode_next;
  logic [HEX_W-1:0]       hex_left, hex_left_next;
  logic [INDEX_BITS-1:0]  position, position_next;
  logic [INDEX_BITS-1:0]  length_held, length_held_next;

  logic                   res_emit;
  logic                   res_fail;
  logic [INDEX_BITS-1:0]  res_idx;
  logic                   s1_go;
  logic                   advance;
  logic [INDEX_BITS-1:0]  pos_inc;
  logic [INDEX_BITS-1:0]  start_inc;

  assign pos_inc   = position + INDEX_BITS'(1);
  assign start_inc = s1_start + INDEX_BITS'(1);

  always_comb begin
    mode_next        = mode;
    hex_left_next    = hex_left;
    position_next    = position;
    length_held_next = length_held;
    res_emit         = 1'b0;
    res_fail         = 1'b0;
    res_idx          = length_held;
    advance          = 1'b0;

    if (s1_first) begin
      length_held_next = s1_len;
      hex_left_next    = '0;
      mode_next        = MODE_BODY;
      res_idx          = s1_len;
      if (s1_start >= s1_len || s1_byte != CH_QUOTE) begin
        res_emit = 1'b1;
        res_fail = 1'b1;
      end else begin
        position_next = start_inc;
        if (start_inc >= s1_len) begin
          res_emit = 1'b1;
          res_fail = 1'b1;
        end
      end
    end else begin
      unique case (mode)
        MODE_BODY: begin
          if (s1_byte == CH_QUOTE) begin
            res_emit = 1'b1;
            res_idx  = pos_inc;
          end else if (s1_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
            advance   = 1'b1;
          end else if (s1_byte < CTRL_LIMIT) begin
            res_emit = 1'b1;
            res_fail = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
        MODE_ESC: begin
          if (s1_byte == CH_U) begin
            // need four bytes after the 'u'
            if ((length_held - pos_inc) < INDEX_BITS'(HEX_COUNT)) begin
              res_emit = 1'b1;
              res_fail = 1'b1;
            end else begin
              mode_next     = MODE_HEX;
              hex_left_next = HEX_COUNT;
              advance       = 1'b1;
            end
          end else begin
            mode_next = MODE_BODY;
            advance   = 1'b1;
          end
        end
        MODE_HEX: begin
          if (!is_hex_digit(s1_byte)) begin
            res_emit = 1'b1;
            res_fail = 1'b1;
          end else begin
            hex_left_next = hex_left - HEX_W'(1);
            if (hex_left == HEX_W'(1)) begin
              mode_next = MODE_BODY;
            end
            advance = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase

      if (advance) begin
        position_next = pos_inc;
        // ran off the end of the buffer
        if (pos_inc >= length_held) begin
          res_emit = 1'b1;
          res_fail = 1'b1;
          res_idx  = length_held;
        end
      end
    end

    if (res_emit) begin
      mode_next     = MODE_IDLE;
      hex_left_next = '0;
    end
  end

  // hold the input register only while a result is blocked by the output
  assign s1_go    = s1_valid && (!res_emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      mode        <= MODE_IDLE;
      hex_left    <= '0;
      position    <= '0;
      length_held <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go) begin
        mode        <= mode_next;
        hex_left    <= hex_left_next;
        position    <= position_next;
        length_held <= length_held_next;
      end

      if (s1_go && res_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_first <= first;
      s1_start <= INDEX_BITS'(start_index);
      s1_len   <= INDEX_BITS'(buffer_length);
    end
    if (s1_go && res_emit) begin
      end_index <= FIELD_W'(res_idx);
      failed    <= res_fail;
    end
  end

  `JSSS_ASSERT_IMP(a_hex_count, (mode == MODE_HEX),
    (hex_left != '0 && hex_left <= HEX_COUNT), "hex count out of range in hex mode")
  `JSSS_ASSERT_IMP(a_pos_in_buf, (mode != MODE_IDLE),
    (position < length_held), "active scan past end of buffer")
  `JSSS_ASSERT_NXT(a_result_loaded, (s1_go && res_emit),
    out_valid, "result not loaded into output register")
  `JSSS_ASSERT_IMP(a_no_drop, (s1_valid && res_emit && out_valid && !out_ready),
    (!in_ready), "input taken while a result is blocked")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for json_string_skip_scanner_unit: directed and random byte streams,
// checked against an in-bench scanner model through a small scoreboard.
// Depends on jsss_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;
  import jsss_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [FIELD_W-1:0] end_index;
    logic               failed;
  } scan_result_t;

  class scan_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [HEX_W-1:0]   hex_left;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] len_held;
    scan_result_t       pending[$];
    int mismatches;
    int live_items;
    int scans;
    int closed;
    int aborted;

    function new();
      mode = MODE_IDLE;
      hex_left = '0;
      pos = '0;
      len_held = '0;
      mismatches = 0;
      live_items = 0;
      scans = 0;
      closed = 0;
      aborted = 0;
    endfunction

    static function bit is_hex(logic [BYTE_W-1:0] c);
      return (c inside {[8'h30:8'h39]}) || ((c | 8'h20) inside {[8'h61:8'h66]});
    endfunction

    function void close_scan(logic [FIELD_W-1:0] idx, logic fail);
      scan_result_t r;
      r.end_index = idx;
      r.failed = fail;
      pending.push_back(r);
      if (fail) aborted++;
      else closed++;
      mode = MODE_IDLE;
      hex_left = '0;
    endfunction

    // Advance the scanner model by one accepted request.
    function void note_byte(logic [BYTE_W-1:0] d, logic f, logic [FIELD_W-1:0] s,
                            logic [FIELD_W-1:0] n);
      if (f) begin
        live_items++;
        scans++;
        len_held = n;
        hex_left = '0;
        mode = MODE_BODY;
        if (s >= n || d != CH_QUOTE) begin
          close_scan(len_held, 1'b1);
          return;
        end
        pos = s + 1;
        if (pos >= len_held) close_scan(len_held, 1'b1);
        return;
      end
      if (mode == MODE_IDLE) return;
      live_items++;
      case (mode)
        MODE_BODY: begin
          if (d == CH_QUOTE) begin
            close_scan(pos + 1, 1'b0);
            return;
          end
          if (d == CH_BACKSLASH) mode = MODE_ESC;
          else if (d < CTRL_LIMIT) begin
            close_scan(len_held, 1'b1);
            return;
          end
        end
        MODE_ESC: begin
          if (d == CH_U) begin
            if (len_held - (pos + 1) < FIELD_W'(HEX_COUNT)) begin
              close_scan(len_held, 1'b1);
              return;
            end
            mode = MODE_HEX;
            hex_left = HEX_COUNT;
          end else begin
            mode = MODE_BODY;
          end
        end
        default: begin
          if (!is_hex(d)) begin
            close_scan(len_held, 1'b1);
            return;
          end
          hex_left = hex_left - HEX_W'(1);
          if (hex_left == '0) mode = MODE_BODY;
        end
      endcase
      pos = pos + 1;
      if (pos >= len_held) close_scan(len_held, 1'b1);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [FIELD_W-1:0] idx, logic fail);
      scan_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result end_index=%0h failed=%0b", idx, fail));
        return;
      end
      want = pending.pop_front();
      if (idx !== want.end_index)
        report_mismatch($sformatf("end_index %0h, want %0h", idx, want.end_index));
      if (fail !== want.failed)
        report_mismatch($sformatf("failed %0b, want %0b", fail, want.failed));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic               first = 1'b0;
  logic [FIELD_W-1:0] start_index = '0;
  logic [FIELD_W-1:0] buffer_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] end_index;
  logic               failed;

  scan_scoreboard sb = new();
  logic [BYTE_W-1:0] scan_bytes[$];
  int send_idle_pct = 9;
  int stall_pct = 56;
  int quiet_cycles = 0;
  int sent_items = 0;

  json_string_skip_scanner_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .first(first),
    .start_index(start_index),
    .buffer_length(buffer_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .end_index(end_index),
    .failed(failed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(end_index, failed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] d, logic f, logic [FIELD_W-1:0] s,
                           logic [FIELD_W-1:0] n);
    logic [FIELD_W-1:0] si;
    logic [FIELD_W-1:0] ni;
    si = f ? s : FIELD_W'($urandom);
    ni = f ? n : FIELD_W'($urandom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    first <= f;
    start_index <= si;
    buffer_length <= ni;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(d, f, si, ni);
    sent_items++;
  endtask

  task automatic play_scan(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] n, int count);
    for (int i = 0; i < count; i++) send_byte(scan_bytes[i], i == 0, s, n);
  endtask

  function automatic logic [BYTE_W-1:0] hex_glyph();
    int v;
    v = $urandom_range(21);
    if (v < 10) return BYTE_W'(8'h30 + v);
    if (v < 16) return BYTE_W'(8'h61 + v - 10);
    return BYTE_W'(8'h41 + v - 16);
  endfunction

  function automatic logic [BYTE_W-1:0] non_hex();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (scan_scoreboard::is_hex(b));
    return b;
  endfunction

  // Build a quoted string of random tokens; faults drop in control bytes and bad hex.
  function automatic void compose_string(int tokens, bit faults);
    int kind;
    logic [BYTE_W-1:0] b;
    scan_bytes.delete();
    scan_bytes.push_back(CH_QUOTE);
    repeat (tokens) begin
      kind = $urandom_range(9);
      if (faults && $urandom_range(5) == 0) begin
        if ($urandom_range(1)) begin
          scan_bytes.push_back(BYTE_W'($urandom_range(CTRL_LIMIT - 1)));
        end else begin
          scan_bytes.push_back(CH_BACKSLASH);
          scan_bytes.push_back(CH_U);
          repeat ($urandom_range(3)) scan_bytes.push_back(hex_glyph());
          scan_bytes.push_back(non_hex());
        end
      end else if (kind < 6) begin
        do b = BYTE_W'($urandom_range(8'hFF, CTRL_LIMIT));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        scan_bytes.push_back(b);
      end else if (kind < 8) begin
        scan_bytes.push_back(CH_BACKSLASH);
        do b = BYTE_W'($urandom); while (b == CH_U);
        scan_bytes.push_back(b);
      end else begin
        scan_bytes.push_back(CH_BACKSLASH);
        scan_bytes.push_back(CH_U);
        repeat (HEX_COUNT) scan_bytes.push_back(hex_glyph());
      end
    end
    scan_bytes.push_back(CH_QUOTE);
  endfunction

  // Keep start + span inside the index range.
  function automatic logic [FIELD_W-1:0] pick_start(int span);
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] top;
    int r;
    top = '1 - FIELD_W'(span);
    r = $urandom_range(9);
    if (r < 6) s = FIELD_W'($urandom_range(300));
    else if (r < 9) s = FIELD_W'($urandom);
    else s = top;
    if (s > top) s = top;
    return s;
  endfunction

  task automatic random_scan();
    int pick;
    int span;
    int extra;
    int count;
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] t;
    pick = $urandom_range(99);
    compose_string($urandom_range(10), pick >= 60 && pick < 80);
    span = scan_bytes.size();
    extra = $urandom_range(3);
    s = pick_start(span + extra);
    n = s + FIELD_W'(span + extra);
    count = span;
    if (pick < 80) begin
      // trailing bytes after the close are dropped by the block
      repeat ($urandom_range(2)) scan_bytes.push_back(BYTE_W'($urandom));
      count = scan_bytes.size();
    end else if (pick < 88) begin
      n = s + FIELD_W'($urandom_range(span - 1, 1));
    end else if (pick < 92) begin
      count = $urandom_range(span - 1, 1);
    end else if (pick < 95) begin
      s = FIELD_W'($urandom);
      n = FIELD_W'($urandom);
      if (n > s) begin
        t = s;
        s = n;
        n = t;
      end
      count = $urandom_range(3, 1);
    end else if (pick < 98) begin
      do scan_bytes[0] = BYTE_W'($urandom); while (scan_bytes[0] == CH_QUOTE);
    end else begin
      foreach (scan_bytes[i]) scan_bytes[i] = BYTE_W'($urandom);
    end
    play_scan(s, n, count);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte with no scan open
    send_byte(8'hA5, 1'b0, '0, '0);
    // start at the end, start past the end
    scan_bytes = '{CH_QUOTE};
    play_scan(32'd5, 32'd5, 1);
    play_scan(32'hFFFF_FFFF, 32'd0, 1);
    // missing opening quote, then an opening quote as the last byte
    scan_bytes = '{8'h78};
    play_scan(32'd0, 32'd10, 1);
    scan_bytes = '{CH_QUOTE};
    play_scan(32'd9, 32'd10, 1);
    // empty string
    scan_bytes = '{CH_QUOTE, CH_QUOTE};
    play_scan(32'd0, 32'd2, 2);
    // control byte in the body
    scan_bytes = '{CH_QUOTE, 8'h1F};
    play_scan(32'd0, 32'd10, 2);
    // top byte value and an escaped quote
    scan_bytes = '{CH_QUOTE, 8'hFF, CH_BACKSLASH, CH_QUOTE, CH_QUOTE};
    play_scan(32'd0, 32'hFFFF_FFFF, 5);
    // backslash as the last byte
    scan_bytes = '{CH_QUOTE, CH_BACKSLASH};
    play_scan(32'd0, 32'd2, 2);
    // unicode escape with too few bytes left
    scan_bytes = '{CH_QUOTE, CH_BACKSLASH, CH_U};
    play_scan(32'd0, 32'd6, 3);
    // non-hex digit just below the digit range
    scan_bytes = '{CH_QUOTE, CH_BACKSLASH, CH_U, 8'h39, 8'h41, 8'h66, 8'h2F};
    play_scan(32'hFFFF_FF00, 32'hFFFF_FFFF, 7);

    while (sent_items < ITEM_TARGET) begin
      if (sent_items < ITEM_TARGET / 3) begin
        send_idle_pct = 9;
        stall_pct = 56;
      end else if (sent_items < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 56;
        stall_pct = 9;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      random_scan();
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; scanned %0d strings over %0d live bytes: %0d closed, %0d failed",
             sent_items, sb.scans, sb.live_items, sb.closed, sb.aborted);
    $display("Result mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
